>>> rtl/soft_knee_compressor_gain_computer_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the soft-knee compressor gain computer.
// ----------------------------------------------------------------------------
`ifndef SOFT_KNEE_COMPRESSOR_GAIN_COMPUTER_MACROS_SVH
`define SOFT_KNEE_COMPRESSOR_GAIN_COMPUTER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SKGC_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SKGC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/skgc_pkg.sv
// ----------------------------------------------------------------------------
// skgc_pkg
// Shared types, constants and elaboration-time tables of the gain computer.
// ----------------------------------------------------------------------------
`default_nettype none

package skgc_pkg;

  // Table size must be a power of two.
  localparam int DB_TABLE_ENTRIES = 256;
  localparam int TAB_BITS         = $clog2(DB_TABLE_ENTRIES);

  // Shared multiplier operand width and product width.
  localparam int MUL_W  = 26;
  localparam int PROD_W = 2 * MUL_W;

  localparam logic [15:0] GAIN_MIN = 16'd1147;
  localparam logic [15:0] GAIN_MAX = 16'd32768;

  typedef logic [DB_TABLE_ENTRIES:0][16:0] log_tab_t;
  typedef logic [DB_TABLE_ENTRIES:0][30:0] exp_tab_t;

  typedef enum logic [2:0] {
    REG_ENV_ATTACK   = 3'd0,
    REG_ENV_RELEASE  = 3'd1,
    REG_GAIN_ATTACK  = 3'd2,
    REG_GAIN_RELEASE = 3'd3,
    REG_THRESHOLD    = 3'd4,
    REG_SLOPE        = 3'd5,
    REG_MAX_RED      = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic [23:0]        env_attack_coeff;
    logic [23:0]        env_release_coeff;
    logic [23:0]        gain_attack_coeff;
    logic [23:0]        gain_release_coeff;
    logic signed [14:0] threshold_db;
    logic [15:0]        slope;
    logic [12:0]        max_reduction_db;
  } cfg_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_ENV_MUL,
    OP_ENV_UPD,
    OP_LOG_MUL,
    OP_DB_MUL,
    OP_KNEE,
    OP_DIV,
    OP_SLOPE,
    OP_CAP,
    OP_EXP_MUL,
    OP_WANT,
    OP_GAIN_MUL,
    OP_GAIN_UPD
  } op_e;

  typedef struct packed {
    logic load_sample;
    op_e  op;
  } cmd_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    v = v_in;
    r = '0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 64'd0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // log2(1 + i/N) in Q1.16 by repeated squaring.
  function automatic log_tab_t build_log_tab();
    log_tab_t    tab;
    logic [63:0] x;
    logic [16:0] y;
    tab = '0;
    for (int i = 0; i < DB_TABLE_ENTRIES; i++) begin
      x = (64'd1 << 30) + (64'(i) << (30 - TAB_BITS));
      y = '0;
      for (int k = 0; k < 16; k++) begin
        x = (x * x) >> 30;
        if (x >= (64'd1 << 31)) begin
          x = x >> 1;
          y[15 - k] = 1'b1;
        end
      end
      tab[i] = y;
    end
    tab[DB_TABLE_ENTRIES] = 17'd65536;
    return tab;
  endfunction

  // 2^(-i/N) in Q1.30 as a product of successive square roots of one half.
  function automatic exp_tab_t build_exp_tab();
    exp_tab_t    tab;
    logic [63:0] root [1:20];
    logic [63:0] fr;
    logic [63:0] v;
    tab = '0;
    root[1] = isqrt64(64'd1 << 59);
    for (int k = 2; k <= 20; k++) root[k] = isqrt64(root[k - 1] << 30);
    for (int i = 0; i < DB_TABLE_ENTRIES; i++) begin
      fr = 64'(i) << (20 - TAB_BITS);
      v  = 64'd1 << 30;
      for (int k = 1; k <= 20; k++) begin
        if (fr[20 - k]) v = (v * root[k]) >> 30;
      end
      tab[i] = 31'(v);
    end
    tab[DB_TABLE_ENTRIES] = 31'd1 << 29;
    return tab;
  endfunction

  localparam log_tab_t LOG_TAB = build_log_tab();
  localparam exp_tab_t EXP_TAB = build_exp_tab();

endpackage

`default_nettype wire

>>> rtl/skgc_cfg.sv
// ----------------------------------------------------------------------------
// skgc_cfg
// Configuration register file written through the configuration channel.
// ----------------------------------------------------------------------------
`default_nettype none

module skgc_cfg import skgc_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  input  wire logic        cfg_ready_i,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [23:0] cfg_data_i,
  output cfg_t             cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.env_attack_coeff   <= 24'd58149;
      cfg_q.env_release_coeff  <= 24'd1589;
      cfg_q.gain_attack_coeff  <= 24'd41072;
      cfg_q.gain_release_coeff <= 24'd1700;
      cfg_q.threshold_db       <= -15'sd4608;
      cfg_q.slope              <= 16'd42130;
      cfg_q.max_reduction_db   <= 13'd4608;
    end else if (cfg_valid_i && cfg_ready_i) begin
      case (cfg_index_i)
        REG_ENV_ATTACK:   cfg_q.env_attack_coeff   <= cfg_data_i;
        REG_ENV_RELEASE:  cfg_q.env_release_coeff  <= cfg_data_i;
        REG_GAIN_ATTACK:  cfg_q.gain_attack_coeff  <= cfg_data_i;
        REG_GAIN_RELEASE: cfg_q.gain_release_coeff <= cfg_data_i;
        REG_THRESHOLD:    cfg_q.threshold_db       <= signed'(cfg_data_i[14:0]);
        REG_SLOPE:        cfg_q.slope              <= cfg_data_i[15:0];
        REG_MAX_RED:      cfg_q.max_reduction_db   <= cfg_data_i[12:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

>>> rtl/skgc_ctrl.sv
// ----------------------------------------------------------------------------
// skgc_ctrl
// Sequencer that steps the datapath through one sample and owns the handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module skgc_ctrl import skgc_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output cmd_t      cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ENV_MUL,
    ST_ENV_UPD,
    ST_LOG_MUL,
    ST_DB_MUL,
    ST_KNEE,
    ST_DIV,
    ST_SLOPE,
    ST_CAP,
    ST_EXP_MUL,
    ST_WANT,
    ST_GAIN_MUL,
    ST_GAIN_UPD
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   out_free;
  logic   accept;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o.load_sample = accept;
    case (state_q)
      ST_ENV_MUL:  cmd_o.op = OP_ENV_MUL;
      ST_ENV_UPD:  cmd_o.op = OP_ENV_UPD;
      ST_LOG_MUL:  cmd_o.op = OP_LOG_MUL;
      ST_DB_MUL:   cmd_o.op = OP_DB_MUL;
      ST_KNEE:     cmd_o.op = OP_KNEE;
      ST_DIV:      cmd_o.op = OP_DIV;
      ST_SLOPE:    cmd_o.op = OP_SLOPE;
      ST_CAP:      cmd_o.op = OP_CAP;
      ST_EXP_MUL:  cmd_o.op = OP_EXP_MUL;
      ST_WANT:     cmd_o.op = OP_WANT;
      ST_GAIN_MUL: cmd_o.op = OP_GAIN_MUL;
      // The final update also loads the output register, so it waits for room.
      ST_GAIN_UPD: cmd_o.op = out_free ? OP_GAIN_UPD : OP_NONE;
      default:     cmd_o.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == ST_GAIN_UPD && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE:     if (accept) state_q <= ST_ENV_MUL;
        ST_ENV_MUL:  state_q <= ST_ENV_UPD;
        ST_ENV_UPD:  state_q <= ST_LOG_MUL;
        ST_LOG_MUL:  state_q <= ST_DB_MUL;
        ST_DB_MUL:   state_q <= ST_KNEE;
        ST_KNEE:     state_q <= ST_DIV;
        ST_DIV:      state_q <= ST_SLOPE;
        ST_SLOPE:    state_q <= ST_CAP;
        ST_CAP:      state_q <= ST_EXP_MUL;
        ST_EXP_MUL:  state_q <= ST_WANT;
        ST_WANT:     state_q <= ST_GAIN_MUL;
        ST_GAIN_MUL: state_q <= ST_GAIN_UPD;
        ST_GAIN_UPD: begin
          if (out_free) state_q <= ST_IDLE;
        end
        default:     state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

>>> rtl/skgc_dp.sv
// ----------------------------------------------------------------------------
// skgc_dp
// Datapath: envelope and gain state, one shared registered multiplier, tables.
// ----------------------------------------------------------------------------
`default_nettype none

module skgc_dp import skgc_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  cmd_t             cmd_i,
  input  cfg_t             cfg_i,
  input  wire logic [15:0] sample_i,
  output logic [15:0]      gain_out_o,
  output logic [12:0]      reduction_db_o
);

  localparam logic signed [17:0] HALF_KNEE = 18'sd640;
  localparam logic signed [17:0] FLOOR_DB  = -18'sd40960;

  logic [15:0]           sample_q;
  logic [23:0]           env_q;
  logic [15:0]           gain_q;
  logic [PROD_W-1:0]     p_q;
  logic [4:0]            e_q;
  logic [TAB_BITS-1:0]   lidx_q;
  logic                  zero_q;
  logic                  neg_q;
  logic signed [17:0]    over_q;
  logic                  knee_q;
  logic                  lin_q;
  logic [12:0]           red_q;
  logic [2:0]            n_q;
  logic [TAB_BITS-1:0]   eidx_q;
  logic [15:0]           want_q;
  logic [15:0]           gain_out_q;
  logic [12:0]           red_out_q;

  logic [MUL_W-1:0]      mul_a;
  logic [MUL_W-1:0]      mul_b;

  // Envelope smoothing.
  logic [16:0]           mag;
  logic [23:0]           rect;
  logic                  env_up;
  logic [23:0]           env_coeff;
  logic [23:0]           env_diff;
  logic [23:0]           env_step;

  // Level conversion.
  logic [4:0]            e_d;
  logic [23:0]           norm;
  logic [TAB_BITS-1:0]   lidx_d;
  logic [22:0]           lr;
  logic [16:0]           ldiff;
  logic [16:0]           frac;
  logic [21:0]           oct_off;
  logic                  l2_neg;
  logic [21:0]           l2_mag;
  logic [PROD_W-1:0]     rnd;
  logic [15:0]           q_db;
  logic signed [17:0]    level;
  logic signed [17:0]    thr_ext;
  logic signed [17:0]    over_d;
  logic [10:0]           knee_o;

  // Reduction and gain.
  logic [16:0]           eff;
  logic [16:0]           sp;
  logic [12:0]           red_d;
  logic [18:0]           oct_t;
  logic [TAB_BITS-1:0]   eidx_d;
  logic [15:0]           er;
  logic [30:0]           ediff;
  logic [30:0]           eval_v;
  logic [30:0]           eshift;
  logic [31:0]           want_sum;
  logic                  g_down;
  logic [23:0]           g_coeff;
  logic [15:0]           g_diff;
  logic [15:0]           g_step;
  logic [16:0]           g_new;

  always_comb begin
    mag       = sample_q[15] ? (17'h10000 - {1'b0, sample_q}) : {1'b0, sample_q};
    rect      = {mag[15:0], 8'h00};
    env_up    = rect > env_q;
    env_coeff = env_up ? cfg_i.env_attack_coeff : cfg_i.env_release_coeff;
    env_diff  = env_up ? rect - env_q : env_q - rect;
    env_step  = 24'(p_q[PROD_W-1:24]);
    if (env_step == 24'd0 && env_coeff != 24'd0) env_step = 24'd1;

    e_d = '0;
    for (int k = 0; k < 24; k++) begin
      if (env_q[k]) e_d = 5'(k);
    end
    norm   = env_q << (5'd23 - e_d);
    lidx_d = norm[22 -: TAB_BITS];
    lr     = {norm[22-TAB_BITS:0], {TAB_BITS{1'b0}}};
    ldiff  = LOG_TAB[32'(lidx_d) + 1] - LOG_TAB[lidx_d];

    frac    = LOG_TAB[lidx_q] + 17'(p_q[PROD_W-1:23]);
    oct_off = 22'(5'd23 - e_q) << 16;
    l2_neg  = oct_off > 22'(frac);
    l2_mag  = l2_neg ? oct_off - 22'(frac) : 22'(frac) - oct_off;

    rnd     = p_q + (PROD_W'(1) << 23);
    q_db    = rnd[39:24];
    if (zero_q)     level = FLOOR_DB;
    else if (neg_q) level = -signed'({2'b00, q_db});
    else            level = signed'({2'b00, q_db});
    thr_ext = {{3{cfg_i.threshold_db[14]}}, cfg_i.threshold_db};
    over_d  = level - thr_ext;
    knee_o  = 11'(over_d + HALF_KNEE);

    if (knee_q)     eff = 17'(p_q[PROD_W-1:16]);
    else if (lin_q) eff = 17'(over_q);
    else            eff = '0;

    sp    = 17'(p_q[PROD_W-1:16]);
    red_d = (sp > 17'(cfg_i.max_reduction_db)) ? cfg_i.max_reduction_db : sp[12:0];

    oct_t  = 19'(p_q[PROD_W-1:8]);
    eidx_d = oct_t[15 -: TAB_BITS];
    er     = {oct_t[15-TAB_BITS:0], {TAB_BITS{1'b0}}};
    ediff  = EXP_TAB[eidx_d] - EXP_TAB[32'(eidx_d) + 1];

    eval_v   = EXP_TAB[eidx_q] - 31'(p_q[PROD_W-1:16]);
    eshift   = eval_v >> n_q;
    want_sum = 32'(eshift) + 32'd16384;

    g_down  = want_q < gain_q;
    g_coeff = g_down ? cfg_i.gain_attack_coeff : cfg_i.gain_release_coeff;
    g_diff  = g_down ? gain_q - want_q : want_q - gain_q;
    g_step  = 16'(p_q[PROD_W-1:24]);
    if (g_step == 16'd0 && g_coeff != 24'd0) g_step = 16'd1;
    if (want_q == gain_q)  g_new = {1'b0, gain_q};
    else if (g_down)       g_new = {1'b0, gain_q} - {1'b0, g_step};
    else                   g_new = {1'b0, gain_q} + {1'b0, g_step};
    if (g_new < 17'(GAIN_MIN))      g_new = 17'(GAIN_MIN);
    else if (g_new > 17'(GAIN_MAX)) g_new = 17'(GAIN_MAX);

    case (cmd_i.op)
      OP_ENV_MUL: begin
        mul_a = MUL_W'(env_coeff);
        mul_b = MUL_W'(env_diff);
      end
      OP_LOG_MUL: begin
        mul_a = MUL_W'(ldiff);
        mul_b = MUL_W'(lr);
      end
      OP_DB_MUL: begin
        mul_a = MUL_W'(l2_mag);
        mul_b = MUL_W'(394566);
      end
      OP_KNEE: begin
        mul_a = MUL_W'(knee_o);
        mul_b = MUL_W'(knee_o);
      end
      OP_DIV: begin
        // Floor division by 2560: drop nine bits, then divide by five.
        mul_a = MUL_W'(p_q[PROD_W-1:9]);
        mul_b = MUL_W'(13108);
      end
      OP_SLOPE: begin
        mul_a = MUL_W'(eff);
        mul_b = MUL_W'(cfg_i.slope);
      end
      OP_CAP: begin
        mul_a = MUL_W'(red_d);
        mul_b = MUL_W'(10885);
      end
      OP_EXP_MUL: begin
        mul_a = MUL_W'(ediff);
        mul_b = MUL_W'(er);
      end
      OP_GAIN_MUL: begin
        mul_a = MUL_W'(g_coeff);
        mul_b = MUL_W'(g_diff);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      env_q  <= '0;
      gain_q <= GAIN_MAX;
    end else begin
      if (cmd_i.op == OP_ENV_UPD && rect != env_q) begin
        env_q <= env_up ? env_q + env_step : env_q - env_step;
      end
      if (cmd_i.op == OP_GAIN_UPD) gain_q <= g_new[15:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_sample) sample_q <= sample_i;
    // The product holds while the sequencer idles, so a stalled final step
    // still sees the gain step.
    if (cmd_i.op != OP_NONE) p_q <= mul_a * mul_b;
    case (cmd_i.op)
      OP_LOG_MUL: begin
        e_q    <= e_d;
        lidx_q <= lidx_d;
        zero_q <= (env_q == 24'd0);
      end
      OP_DB_MUL: neg_q <= l2_neg;
      OP_KNEE: begin
        over_q <= over_d;
        knee_q <= (over_d > -HALF_KNEE) && (over_d < HALF_KNEE);
        lin_q  <= (over_d >= HALF_KNEE);
      end
      OP_CAP: red_q <= red_d;
      OP_EXP_MUL: begin
        n_q    <= oct_t[18:16];
        eidx_q <= eidx_d;
      end
      OP_WANT: want_q <= want_sum[30:15];
      OP_GAIN_UPD: begin
        gain_out_q <= g_new[15:0];
        red_out_q  <= red_q;
      end
      default: ;
    endcase
  end

  assign gain_out_o     = gain_out_q;
  assign reduction_db_o = red_out_q;

endmodule

`default_nettype wire

>>> rtl/soft_knee_compressor_gain_computer.sv
// ----------------------------------------------------------------------------
// soft_knee_compressor_gain_computer
// One compressor band detector: envelope, dB level, soft knee and smoothed gain.
// ----------------------------------------------------------------------------
// Usage:
// Samples enter on the s_axis stream (signed Q1.15 in tdata[15:0]). Each
// result leaves on the m_axis stream with the smoothed gain and the target
// reduction of that sample. A configuration request writes one register
// through cfg_index_i / cfg_data_i; it is always ready and should be used
// only while no sample is in flight.
// A result follows an accepted request after the twelve steps that share
// the single registered multiplier. The next request is taken only once the
// sequencer is back in its idle state.
// s_axis_tready is high only between samples.
// When the receiver stalls, the result is held in the output register and
// the next sample is still accepted; its final step waits until that
// register is free. Reset clears the envelope, sets the gain to unity and
// loads the default register values.
`default_nettype none

`include "soft_knee_compressor_gain_computer_macros.svh"

module soft_knee_compressor_gain_computer import skgc_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // [15:0] sample
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // [15:0] gain_out, [28:16] reduction_db
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [23:0] cfg_data_i
);

  cfg_t        cfg;
  cmd_t        cmd;
  logic [15:0] gain_out;
  logic [12:0] reduction_db;

  assign cfg_ready_o = 1'b1;

  skgc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_i (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  skgc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  skgc_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .cfg_i          (cfg),
    .sample_i       (s_axis_tdata),
    .gain_out_o     (gain_out),
    .reduction_db_o (reduction_db)
  );

  assign m_axis_tdata = {3'b000, reduction_db, gain_out};

  `SKGC_ASSERT_NOW(a_gain_range, clk_i, rst_ni, m_axis_tvalid, (gain_out >= GAIN_MIN) && (gain_out <= GAIN_MAX), "gain outside clamp range")
  `SKGC_ASSERT_NOW(a_red_cap, clk_i, rst_ni, m_axis_tvalid, reduction_db <= cfg.max_reduction_db, "reduction above cap")
  `SKGC_ASSERT_NEXT(a_one_at_a_time, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready, "request accepted while busy")

endmodule

`default_nettype wire
